// ----- src/allocation_bitmap_engine_unit_macros.svh -----
// ============================================================================
// Assertion macros for the allocation bitmap engine
// Property forms used by the sequencer to check its own logic.
// ============================================================================
`ifndef ALLOCATION_BITMAP_ENGINE_UNIT_MACROS_SVH
`define ALLOCATION_BITMAP_ENGINE_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ABE_ASSERT_IMPL(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ABE_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- src/abe_pkg.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Allocation bitmap engine package
// Command and status codes, sequencer states and the request and result
// records shared by the engine's modules.
// ============================================================================
package abe_pkg;

	// Fixed field widths.
	localparam int CMD_W = 3;
	localparam int IDX_W = 10;
	localparam int LEN_W = 11;
	localparam int CFG_W = 11;
	localparam int ST_W = 2;
	// Wide positions: sizes, word bases, run starts and run counts.
	localparam int POS_W = 12;

	// Stream payload widths.
	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 16;

	// Reset value of the size register.
	localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

	typedef enum logic [CMD_W-1:0] {
		CMD_SET_BIT     = 3'd0,
		CMD_CLEAR_BIT   = 3'd1,
		CMD_TEST_BIT    = 3'd2,
		CMD_SET_ALL     = 3'd3,
		CMD_CLEAR_ALL   = 3'd4,
		CMD_FIRST_SET   = 3'd5,
		CMD_FIRST_CLEAR = 3'd6,
		CMD_FIND_RUN    = 3'd7
	} cmd_t;

	typedef enum logic [ST_W-1:0] {
		ST_OK    = 2'd0,
		ST_NONE  = 2'd1,
		ST_RANGE = 2'd2
	} status_t;

	// What the scan unit looks for in a word.
	typedef enum logic [1:0] {
		SCAN_SET,
		SCAN_CLEAR,
		SCAN_STOP
	} scan_mode_t;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_START,
		S_READ,
		S_SCAN,
		S_DONE
	} seq_state_t;

	typedef struct packed {
		cmd_t              command;
		logic [IDX_W-1:0]  bit_index;
		logic [LEN_W-1:0]  run_length;
		logic [CFG_W-1:0]  size;
	} req_t;

	typedef struct packed {
		logic [IDX_W-1:0]  result_index;
		logic              bit_value;
		status_t           status;
	} res_t;

endpackage

// ----- src/allocation_bitmap_engine_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Allocation bitmap engine
// Bitmap of allocation marks with set, clear, test, set all, clear all,
// first set, first clear and clear-run search commands.
// ============================================================================
//  Channel   Direction  Signals                          Carries
//  s_axis    in         tvalid tready tdata tuser        one command
//  m_axis    out        tvalid tready tdata tuser        one result
//  cfg       in         cfg_we cfg_wdata                 bits_in_use
//
//  One command at a time; the sequencer reads a bitmap word in S_READ and
//  scans it in S_SCAN. Set, clear and test pass over the words below the
//  one holding bit_index without reading them; other commands read each word
//  in turn, and a run search rescans a word after each in-use set bit below
//  its top bit. Reset zeroes all MAX_BITS / WORD_BITS words (rounded up).
//  A result waits in the output register while the next command runs.
// ============================================================================
module allocation_bitmap_engine_unit #(
	parameter int MAX_BITS = 1024,
	parameter int WORD_BITS = 32
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	// [9:0] bit_index, [20:10] run_length, [23:21] zero
	input  logic [abe_pkg::S_TDATA_W-1:0]    s_axis_tdata,
	// [2:0] command
	input  logic [abe_pkg::CMD_W-1:0]        s_axis_tuser,
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [9:0] result_index, [10] bit_value, [15:11] zero
	output logic [abe_pkg::M_TDATA_W-1:0]    m_axis_tdata,
	// [1:0] status
	output logic [abe_pkg::ST_W-1:0]         m_axis_tuser,
	input  logic                             cfg_we,
	input  logic [abe_pkg::CFG_W-1:0]        cfg_wdata
);

	localparam int WORD_COUNT = (MAX_BITS + WORD_BITS - 1) / WORD_BITS;
	localparam int ADDR_W = (WORD_COUNT > 1) ? $clog2(WORD_COUNT) : 1;
	localparam int PB_W = $clog2(WORD_BITS);

	logic [abe_pkg::CFG_W-1:0] bits_in_use_q;
	logic [abe_pkg::CFG_W-1:0] size;
	abe_pkg::req_t             req;
	abe_pkg::res_t             res;
	logic                      res_valid;
	logic                      res_ack;
	logic                      out_valid_q;
	abe_pkg::res_t             out_res_q;

	// Size register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bits_in_use_q <= abe_pkg::CFG_RESET;
		end else if (cfg_we) begin
			bits_in_use_q <= cfg_wdata;
		end
	end

	// Sizes above the bitmap act as the whole bitmap.
	always_comb begin
		if (32'(bits_in_use_q) > MAX_BITS) begin
			size = abe_pkg::CFG_W'(MAX_BITS);
		end else begin
			size = bits_in_use_q;
		end
	end

	// Unpack the command transfer.
	always_comb begin
		req.command    = abe_pkg::cmd_t'(s_axis_tuser);
		req.bit_index  = s_axis_tdata[abe_pkg::IDX_W-1:0];
		req.run_length = s_axis_tdata[abe_pkg::IDX_W+abe_pkg::LEN_W-1:abe_pkg::IDX_W];
		req.size       = size;
	end

	abe_sequencer #(
		.WORD_BITS(WORD_BITS),
		.WORD_COUNT(WORD_COUNT),
		.ADDR_W(ADDR_W),
		.PB_W(PB_W)
	) u_seq (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(s_axis_tvalid),
		.req_ready(s_axis_tready),
		.req(req),
		.res_valid(res_valid),
		.res_ack(res_ack),
		.res(res)
	);

	// Output register: loads when empty or when its result is being taken.
	assign res_ack = res_valid && (!out_valid_q || m_axis_tready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ack) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ack) begin
			out_res_q <= res;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {{(abe_pkg::M_TDATA_W - abe_pkg::IDX_W - 1){1'b0}},
		out_res_q.bit_value, out_res_q.result_index};
	assign m_axis_tuser  = out_res_q.status;

endmodule

// ----- src/abe_scan_unit.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Bitmap word scan unit
// Builds the in-use mask of one word and finds the lowest in-use set or clear
// bit, or the lowest stop bit at or above a starting offset.
// ============================================================================
module abe_scan_unit #(
	parameter int WORD_BITS = 32,
	parameter int PB_W = 5
) (
	input  logic [WORD_BITS-1:0]         word,
	input  logic [abe_pkg::POS_W-1:0]    lim,
	input  logic [PB_W-1:0]              off,
	input  abe_pkg::scan_mode_t          mode,
	output logic [WORD_BITS-1:0]         inmask,
	output logic                         hit,
	output logic [PB_W-1:0]              pos
);

	logic [WORD_BITS-1:0] offmask;
	logic [WORD_BITS-1:0] vec;

	// Bits below the limit are in use; bits below the offset are already seen.
	always_comb begin
		for (int j = 0; j < WORD_BITS; j++) begin
			inmask[j]  = abe_pkg::POS_W'(j) < lim;
			offmask[j] = PB_W'(j) >= off;
		end
	end

	// Select the bits that end the search; bits past the size stop a run.
	always_comb begin
		case (mode)
			abe_pkg::SCAN_SET:   vec = word & inmask;
			abe_pkg::SCAN_CLEAR: vec = ~word & inmask;
			abe_pkg::SCAN_STOP:  vec = (word | ~inmask) & offmask;
			default:             vec = '0;
		endcase
	end

	// Lowest-first priority encoder.
	always_comb begin
		hit = |vec;
		pos = '0;
		for (int j = WORD_BITS - 1; j >= 0; j--) begin
			if (vec[j]) begin
				pos = PB_W'(j);
			end
		end
	end

endmodule

// ----- src/abe_bitmap_store.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Bitmap word store
// One write port and one read port with registered read data.
// ============================================================================
module abe_bitmap_store #(
	parameter int WORD_BITS = 32,
	parameter int WORD_COUNT = 32,
	parameter int ADDR_W = 5
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [ADDR_W-1:0]     wr_addr,
	input  logic [WORD_BITS-1:0]  wr_data,
	input  logic                  rd_en,
	input  logic [ADDR_W-1:0]     rd_addr,
	output logic [WORD_BITS-1:0]  rd_data
);

	logic [WORD_BITS-1:0] mem_q [WORD_COUNT];
	logic [WORD_BITS-1:0] rd_data_q;

	// Write port.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// Read port; the data holds until the next read.
	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ----- src/abe_sequencer.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Bitmap command sequencer
// Walks the bitmap one word at a time through the shared scan unit and
// carries out one command, then hands over its result.
// ============================================================================
`include "allocation_bitmap_engine_unit_macros.svh"

module abe_sequencer #(
	parameter int WORD_BITS = 32,
	parameter int WORD_COUNT = 32,
	parameter int ADDR_W = 5,
	parameter int PB_W = 5
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  abe_pkg::req_t  req,
	output logic           res_valid,
	input  logic           res_ack,
	output abe_pkg::res_t  res
);

	localparam int POS_W = abe_pkg::POS_W;

	abe_pkg::seq_state_t state_q, state_next;
	abe_pkg::req_t       req_norm;
	abe_pkg::req_t       cmd_q;
	logic [ADDR_W-1:0]   w_q;
	logic [POS_W-1:0]    base_q;
	logic [PB_W-1:0]     off_q;
	logic [POS_W-1:0]    cnt_q;
	logic [POS_W-1:0]    rs_q;
	abe_pkg::res_t       res_q;

	logic                mem_wr_en;
	logic [WORD_BITS-1:0] mem_wr_data;
	logic                mem_rd_en;
	logic [WORD_BITS-1:0] word;

	abe_pkg::scan_mode_t scan_mode;
	logic [WORD_BITS-1:0] inmask;
	logic                hit;
	logic [PB_W-1:0]     pos;

	logic [POS_W-1:0]    size_w;
	logic [POS_W-1:0]    idx_w;
	logic [POS_W-1:0]    next_base;
	logic [POS_W-1:0]    lim;
	logic [PB_W-1:0]     bit_off;
	logic [WORD_BITS-1:0] one_hot;
	logic [POS_W-1:0]    seg;
	logic [POS_W-1:0]    total;
	logic                run_done;
	logic                word_end;
	logic                more;
	logic                bit_op;

	logic                fin;
	logic                adv;
	logic                rescan;
	logic [POS_W-1:0]    fin_idx;
	logic                fin_bval;
	abe_pkg::status_t    fin_status;

	// Shared word arithmetic.
	assign size_w    = POS_W'(cmd_q.size);
	assign idx_w     = POS_W'(cmd_q.bit_index);
	assign next_base = base_q + POS_W'(WORD_BITS);
	assign lim       = size_w - base_q;
	assign bit_off   = PB_W'(idx_w - base_q);
	assign one_hot   = WORD_BITS'(1) << bit_off;
	assign more      = next_base < size_w;
	assign bit_op    = cmd_q.command inside {abe_pkg::CMD_SET_BIT, abe_pkg::CMD_CLEAR_BIT,
		abe_pkg::CMD_TEST_BIT};

	// Run bookkeeping: clear bits from the offset up to the stop bit.
	assign seg      = (hit ? POS_W'(pos) : POS_W'(WORD_BITS)) - POS_W'(off_q);
	assign total    = cnt_q + seg;
	assign run_done = total >= POS_W'(cmd_q.run_length);
	assign word_end = pos == PB_W'(WORD_BITS - 1);

	// A zero run length asks for a single clear bit.
	always_comb begin
		req_norm = req;
		if (req.run_length == '0) begin
			req_norm.run_length = abe_pkg::LEN_W'(1);
		end
	end

	always_comb begin
		case (cmd_q.command)
			abe_pkg::CMD_FIRST_SET:   scan_mode = abe_pkg::SCAN_SET;
			abe_pkg::CMD_FIRST_CLEAR: scan_mode = abe_pkg::SCAN_CLEAR;
			default:                  scan_mode = abe_pkg::SCAN_STOP;
		endcase
	end

	abe_scan_unit #(
		.WORD_BITS(WORD_BITS),
		.PB_W(PB_W)
	) u_scan (
		.word(word),
		.lim(lim),
		.off(off_q),
		.mode(scan_mode),
		.inmask(inmask),
		.hit(hit),
		.pos(pos)
	);

	abe_bitmap_store #(
		.WORD_BITS(WORD_BITS),
		.WORD_COUNT(WORD_COUNT),
		.ADDR_W(ADDR_W)
	) u_store (
		.clk(clk),
		.wr_en(mem_wr_en),
		.wr_addr(w_q),
		.wr_data(mem_wr_data),
		.rd_en(mem_rd_en),
		.rd_addr(w_q),
		.rd_data(word)
	);

	// Outputs and per-state decisions.
	always_comb begin
		req_ready   = 1'b0;
		res_valid   = 1'b0;
		mem_wr_en   = 1'b0;
		mem_wr_data = '0;
		mem_rd_en   = 1'b0;
		fin         = 1'b0;
		adv         = 1'b0;
		rescan      = 1'b0;
		fin_idx     = '0;
		fin_bval    = 1'b0;
		fin_status  = abe_pkg::ST_OK;
		case (state_q)
			abe_pkg::S_CLEAR: begin
				mem_wr_en = 1'b1;
			end
			abe_pkg::S_IDLE: begin
				req_ready = 1'b1;
			end
			abe_pkg::S_START: begin
				if (size_w == '0) begin
					fin = 1'b1;
					if (bit_op) begin
						fin_status = abe_pkg::ST_RANGE;
					end else if (cmd_q.command inside {abe_pkg::CMD_SET_ALL,
						abe_pkg::CMD_CLEAR_ALL}) begin
						fin_status = abe_pkg::ST_OK;
					end else begin
						fin_status = abe_pkg::ST_NONE;
					end
				end else if (bit_op && idx_w >= size_w) begin
					fin        = 1'b1;
					fin_status = abe_pkg::ST_RANGE;
				end
			end
			abe_pkg::S_READ: begin
				// Single-bit commands skip words until the one holding the index.
				if (bit_op && idx_w >= next_base) begin
					adv = 1'b1;
				end else begin
					mem_rd_en = 1'b1;
				end
			end
			abe_pkg::S_SCAN: begin
				case (cmd_q.command)
					abe_pkg::CMD_SET_BIT: begin
						mem_wr_en   = 1'b1;
						mem_wr_data = word | one_hot;
						fin         = 1'b1;
					end
					abe_pkg::CMD_CLEAR_BIT: begin
						mem_wr_en   = 1'b1;
						mem_wr_data = word & ~one_hot;
						fin         = 1'b1;
					end
					abe_pkg::CMD_TEST_BIT: begin
						fin      = 1'b1;
						fin_bval = word[bit_off];
					end
					abe_pkg::CMD_SET_ALL, abe_pkg::CMD_CLEAR_ALL: begin
						mem_wr_en   = 1'b1;
						mem_wr_data = (cmd_q.command == abe_pkg::CMD_SET_ALL) ?
							(word | inmask) : (word & ~inmask);
						adv = more;
						fin = !more;
					end
					abe_pkg::CMD_FIRST_SET, abe_pkg::CMD_FIRST_CLEAR: begin
						if (hit) begin
							fin     = 1'b1;
							fin_idx = base_q + POS_W'(pos);
						end else if (more) begin
							adv = 1'b1;
						end else begin
							fin        = 1'b1;
							fin_status = abe_pkg::ST_NONE;
						end
					end
					default: begin
						// Run search: the run began at the recorded start.
						if (run_done) begin
							fin     = 1'b1;
							fin_idx = rs_q;
						end else if (hit && !inmask[pos]) begin
							fin        = 1'b1;
							fin_status = abe_pkg::ST_NONE;
						end else if (hit && !word_end) begin
							rescan = 1'b1;
						end else if (more) begin
							adv = 1'b1;
						end else begin
							fin        = 1'b1;
							fin_status = abe_pkg::ST_NONE;
						end
					end
				endcase
			end
			abe_pkg::S_DONE: begin
				res_valid = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Next state.
	always_comb begin
		state_next = state_q;
		case (state_q)
			abe_pkg::S_CLEAR: begin
				if (w_q == ADDR_W'(WORD_COUNT - 1)) begin
					state_next = abe_pkg::S_IDLE;
				end
			end
			abe_pkg::S_IDLE: begin
				if (req_valid) begin
					state_next = abe_pkg::S_START;
				end
			end
			abe_pkg::S_START: begin
				state_next = fin ? abe_pkg::S_DONE : abe_pkg::S_READ;
			end
			abe_pkg::S_READ: begin
				if (mem_rd_en) begin
					state_next = abe_pkg::S_SCAN;
				end
			end
			abe_pkg::S_SCAN: begin
				if (fin) begin
					state_next = abe_pkg::S_DONE;
				end else if (adv) begin
					state_next = abe_pkg::S_READ;
				end
			end
			abe_pkg::S_DONE: begin
				if (res_ack) begin
					state_next = abe_pkg::S_IDLE;
				end
			end
			default: begin
				state_next = abe_pkg::S_IDLE;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= abe_pkg::S_CLEAR;
			w_q     <= '0;
		end else begin
			state_q <= state_next;
			if (state_q == abe_pkg::S_CLEAR) begin
				w_q <= (w_q == ADDR_W'(WORD_COUNT - 1)) ? '0 : w_q + ADDR_W'(1);
			end else if (state_q == abe_pkg::S_IDLE) begin
				w_q <= '0;
			end else if (adv) begin
				w_q <= w_q + ADDR_W'(1);
			end
		end
	end

	// Command and walk registers.
	always_ff @(posedge clk) begin
		if (state_q == abe_pkg::S_IDLE && req_valid) begin
			cmd_q  <= req_norm;
			base_q <= '0;
			off_q  <= '0;
			cnt_q  <= '0;
			rs_q   <= '0;
		end else if (adv) begin
			base_q <= next_base;
			off_q  <= '0;
			if (hit) begin
				cnt_q <= '0;
				rs_q  <= next_base;
			end else begin
				cnt_q <= total;
			end
		end else if (rescan) begin
			off_q <= pos + PB_W'(1);
			cnt_q <= '0;
			rs_q  <= base_q + POS_W'(pos) + POS_W'(1);
		end
		if (fin) begin
			res_q.result_index <= fin_idx[abe_pkg::IDX_W-1:0];
			res_q.bit_value    <= fin_bval;
			res_q.status       <= fin_status;
		end
	end

	assign res = res_q;

	`ABE_ASSERT_IMPL(a_no_write_idle, clk, arst_n,
		(state_q == abe_pkg::S_IDLE || state_q == abe_pkg::S_DONE), !mem_wr_en,
		"bitmap written while no command is active")
	`ABE_ASSERT_IMPL(a_range_bit_op, clk, arst_n,
		(res_valid && res.status == abe_pkg::ST_RANGE), bit_op,
		"range error on a command without an index")
	`ABE_ASSERT_IMPL(a_bval_test, clk, arst_n,
		(res_valid && res.bit_value), (cmd_q.command == abe_pkg::CMD_TEST_BIT),
		"bit value set for a command other than test")
	`ABE_ASSERT_NEXT(a_read_then_scan, clk, arst_n,
		(state_q == abe_pkg::S_READ && mem_rd_en), (state_q == abe_pkg::S_SCAN),
		"word read not followed by a scan")

endmodule

// ----- verif/allocation_bitmap_engine_unit_test.sv -----
`timescale 1ns / 1ps
// ============================================================================
// Allocation bitmap engine testbench
// Sends bitmap commands over the input stream and checks each result against
// a bitmap kept in the bench, or a typed row's result. A short directed table
// covering the size register extremes comes first, then random phases at
// several sizes. Idle bursts are enabled at random per phase, never in the last.
// ============================================================================
module allocation_bitmap_engine_unit_test;
	import abe_pkg::*;

	localparam int MARKS = 1024;
	localparam int PLAN_ROWS = 31;
	localparam int PHASES = 10;
	localparam int PHASE_ITEMS = 70;
	localparam int QUIET_LIMIT = 20000;
	localparam int TAIL_CYCLES = 100;

	// One row of the directed table: a size write or a command.
	typedef struct {
		bit               is_cfg;
		cmd_t             command;
		logic [IDX_W-1:0] bit_index;
		logic [LEN_W-1:0] run_length;
		logic [CFG_W-1:0] size;
		bit               typed;
		logic [IDX_W-1:0] exp_index;
		logic             exp_bit;
		status_t          exp_status;
	} plan_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [S_TDATA_W-1:0] s_axis_tdata;
	logic [CMD_W-1:0]     s_axis_tuser;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [M_TDATA_W-1:0] m_axis_tdata;
	logic [ST_W-1:0]      m_axis_tuser;
	logic                 cfg_we;
	logic [CFG_W-1:0]     cfg_wdata;

	// Bench copy of the bitmap and the size register.
	bit [MARKS-1:0]   mark_bits;
	logic [CFG_W-1:0] size_reg;
	res_t             outcome_queue[$];
	int               errors;
	int               quiet_cycles;
	bit               tx_gaps;
	bit               rx_gaps;

	plan_row_t plan [PLAN_ROWS] = '{
		'{1'b0, CMD_TEST_BIT,    10'd0,    11'd0,    11'd0, 1'b1, 10'd0,    1'b0, ST_OK},
		'{1'b0, CMD_FIRST_SET,   10'd0,    11'd0,    11'd0, 1'b1, 10'd0,    1'b0, ST_NONE},
		'{1'b0, CMD_FIRST_CLEAR, 10'd0,    11'd0,    11'd0, 1'b1, 10'd0,    1'b0, ST_OK},
		'{1'b0, CMD_FIND_RUN,    10'd0,    11'd1024, 11'd0, 1'b1, 10'd0,    1'b0, ST_OK},
		'{1'b0, CMD_FIND_RUN,    10'd0,    11'd0,    11'd0, 1'b1, 10'd0,    1'b0, ST_OK},
		'{1'b0, CMD_FIND_RUN,    10'd0,    11'd2047, 11'd0, 1'b1, 10'd0,    1'b0, ST_NONE},
		'{1'b0, CMD_SET_BIT,     10'd1023, 11'd0,    11'd0, 1'b1, 10'd0,    1'b0, ST_OK},
		'{1'b0, CMD_TEST_BIT,    10'd1023, 11'd0,    11'd0, 1'b1, 10'd0,    1'b1, ST_OK},
		'{1'b0, CMD_SET_BIT,     10'd0,    11'd0,    11'd0, 1'b1, 10'd0,    1'b0, ST_OK},
		'{1'b0, CMD_FIND_RUN,    10'd0,    11'd1022, 11'd0, 1'b1, 10'd1,    1'b0, ST_OK},
		'{1'b0, CMD_CLEAR_BIT,   10'd0,    11'd0,    11'd0, 1'b1, 10'd0,    1'b0, ST_OK},
		'{1'b0, CMD_FIRST_SET,   10'd0,    11'd0,    11'd0, 1'b1, 10'd1023, 1'b0, ST_OK},
		'{1'b0, CMD_SET_ALL,     10'd0,    11'd0,    11'd0, 1'b1, 10'd0,    1'b0, ST_OK},
		'{1'b0, CMD_FIRST_CLEAR, 10'd0,    11'd0,    11'd0, 1'b1, 10'd0,    1'b0, ST_NONE},
		'{1'b0, CMD_CLEAR_BIT,   10'd31,   11'd0,    11'd0, 1'b0, 10'd0,    1'b0, ST_OK},
		'{1'b0, CMD_CLEAR_BIT,   10'd32,   11'd0,    11'd0, 1'b0, 10'd0,    1'b0, ST_OK},
		'{1'b0, CMD_CLEAR_BIT,   10'd517,  11'd0,    11'd0, 1'b0, 10'd0,    1'b0, ST_OK},
		'{1'b0, CMD_FIND_RUN,    10'd0,    11'd2,    11'd0, 1'b0, 10'd0,    1'b0, ST_OK},
		'{1'b1, CMD_SET_BIT,     10'd0,    11'd0,    11'd40, 1'b0, 10'd0,   1'b0, ST_OK},
		'{1'b0, CMD_SET_BIT,     10'd40,   11'd0,    11'd0, 1'b1, 10'd0,    1'b0, ST_RANGE},
		'{1'b0, CMD_TEST_BIT,    10'd1023, 11'd0,    11'd0, 1'b1, 10'd0,    1'b0, ST_RANGE},
		'{1'b0, CMD_CLEAR_ALL,   10'd0,    11'd0,    11'd0, 1'b1, 10'd0,    1'b0, ST_OK},
		'{1'b0, CMD_FIRST_SET,   10'd0,    11'd0,    11'd0, 1'b1, 10'd0,    1'b0, ST_NONE},
		'{1'b1, CMD_SET_BIT,     10'd0,    11'd0,    11'd1024, 1'b0, 10'd0, 1'b0, ST_OK},
		'{1'b0, CMD_FIRST_SET,   10'd0,    11'd0,    11'd0, 1'b0, 10'd0,    1'b0, ST_OK},
		'{1'b1, CMD_SET_BIT,     10'd0,    11'd0,    11'd0, 1'b0, 10'd0,    1'b0, ST_OK},
		'{1'b0, CMD_SET_BIT,     10'd0,    11'd0,    11'd0, 1'b1, 10'd0,    1'b0, ST_RANGE},
		'{1'b0, CMD_FIND_RUN,    10'd0,    11'd0,    11'd0, 1'b1, 10'd0,    1'b0, ST_NONE},
		'{1'b0, CMD_SET_ALL,     10'd0,    11'd0,    11'd0, 1'b1, 10'd0,    1'b0, ST_OK},
		'{1'b1, CMD_SET_BIT,     10'd0,    11'd0,    11'd2047, 1'b0, 10'd0, 1'b0, ST_OK},
		'{1'b0, CMD_FIRST_SET,   10'd0,    11'd0,    11'd0, 1'b0, 10'd0,    1'b0, ST_OK}
	};

	// Size values for the random phases; a negative entry draws a random size.
	int size_plan [PHASES] = '{1024, 1, 33, 2047, 0, 64, 31, -1, -1, 1024};

	allocation_bitmap_engine_unit u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata)
	);

	// Clock with a 4 ns period.
	always begin
		clk = 1'b0;
		#2;
		clk = 1'b1;
		#2;
	end

	// Number of marks that commands may touch.
	function automatic int active_marks();
		return (size_reg > MARKS) ? MARKS : int'(size_reg);
	endfunction

	// Applies one command to the bench bitmap and returns the result it gives.
	function automatic res_t bitmap_outcome(cmd_t cmd, logic [IDX_W-1:0] idx,
			logic [LEN_W-1:0] len);
		res_t r;
		int   limit;
		int   need;
		int   count;
		limit = active_marks();
		r.result_index = '0;
		r.bit_value = 1'b0;
		r.status = ST_OK;
		case (cmd)
			CMD_SET_BIT, CMD_CLEAR_BIT, CMD_TEST_BIT: begin
				if (int'(idx) >= limit)
					r.status = ST_RANGE;
				else if (cmd == CMD_SET_BIT)
					mark_bits[idx] = 1'b1;
				else if (cmd == CMD_CLEAR_BIT)
					mark_bits[idx] = 1'b0;
				else
					r.bit_value = mark_bits[idx];
			end
			CMD_SET_ALL, CMD_CLEAR_ALL: begin
				for (int i = 0; i < limit; i++)
					mark_bits[i] = (cmd == CMD_SET_ALL);
			end
			CMD_FIRST_SET, CMD_FIRST_CLEAR: begin
				r.status = ST_NONE;
				for (int i = 0; i < limit; i++) begin
					if (mark_bits[i] == (cmd == CMD_FIRST_SET)) begin
						r.result_index = IDX_W'(i);
						r.status = ST_OK;
						break;
					end
				end
			end
			default: begin
				// A run restarts after every set mark and may span words.
				need = (len == 0) ? 1 : int'(len);
				count = 0;
				r.status = ST_NONE;
				for (int i = 0; i < limit; i++) begin
					if (mark_bits[i]) begin
						count = 0;
					end else begin
						count++;
						if (count >= need) begin
							r.result_index = IDX_W'(i + 1 - need);
							r.status = ST_OK;
							break;
						end
					end
				end
			end
		endcase
		return r;
	endfunction

	// Presents one command and waits for its transfer, then records what it
	// should give back.
	task automatic issue(cmd_t cmd, logic [IDX_W-1:0] idx, logic [LEN_W-1:0] len,
			bit typed, res_t typed_res);
		res_t predicted;
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= {3'b000, len, idx};
		s_axis_tuser <= cmd;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		predicted = bitmap_outcome(cmd, idx, len);
		outcome_queue.push_back(typed ? typed_res : predicted);
	endtask

	// Random gap on the input side before a command.
	task automatic maybe_gap();
		int n;
		if (tx_gaps && $urandom_range(0, 2) == 0) begin
			n = $urandom_range(1, 13);
			s_axis_tvalid <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// Stops sending and waits until every result has come back.
	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (outcome_queue.size() != 0)
			@(posedge clk);
	endtask

	// Writes the size register once the engine has gone idle.
	task automatic write_size(logic [CFG_W-1:0] value);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we <= 1'b0;
		size_reg = value;
	endtask

	// Draws one random command, weighted toward single-mark updates so that
	// the searches meet a mixed bitmap.
	task automatic pick_command(output cmd_t cmd, output logic [IDX_W-1:0] idx,
			output logic [LEN_W-1:0] len);
		int pick;
		int limit;
		int r;
		limit = active_marks();
		pick = $urandom_range(0, 99);
		if (pick < 28)
			cmd = CMD_SET_BIT;
		else if (pick < 52)
			cmd = CMD_CLEAR_BIT;
		else if (pick < 60)
			cmd = CMD_TEST_BIT;
		else if (pick < 62)
			cmd = CMD_SET_ALL;
		else if (pick < 65)
			cmd = CMD_CLEAR_ALL;
		else if (pick < 73)
			cmd = CMD_FIRST_SET;
		else if (pick < 81)
			cmd = CMD_FIRST_CLEAR;
		else
			cmd = CMD_FIND_RUN;

		// Mostly in-range positions, sometimes any position.
		if (limit != 0 && $urandom_range(0, 7) != 0)
			idx = IDX_W'($urandom_range(0, limit - 1));
		else
			idx = IDX_W'($urandom);

		// Mostly short runs, with whole-field values and too-long runs mixed in.
		r = $urandom_range(0, 9);
		if (r == 0)
			len = LEN_W'($urandom);
		else if (r == 1)
			len = LEN_W'($urandom_range(0, limit));
		else if (r == 2)
			len = LEN_W'(limit + 1);
		else
			len = LEN_W'($urandom_range(1, 24));
	endtask

	// Result checker and watchdog.
	always @(posedge clk) begin : result_check
		res_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (outcome_queue.size() == 0) begin
				$display("%0t: result with none expected: index %0d bit %0b status %0d",
					$time, m_axis_tdata[9:0], m_axis_tdata[10], m_axis_tuser);
				errors++;
			end else begin
				want = outcome_queue.pop_front();
				if (m_axis_tdata[9:0] !== want.result_index) begin
					$display("%0t: result_index expected %0d actual %0d",
						$time, want.result_index, m_axis_tdata[9:0]);
					errors++;
				end
				if (m_axis_tdata[10] !== want.bit_value) begin
					$display("%0t: bit_value expected %0b actual %0b",
						$time, want.bit_value, m_axis_tdata[10]);
					errors++;
				end
				if (m_axis_tuser !== want.status) begin
					$display("%0t: status expected %0d actual %0d",
						$time, want.status, m_axis_tuser);
					errors++;
				end
			end
		end

		// Count cycles in which no transfer happens on either stream.
		if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
			quiet_cycles = 0;
		else
			quiet_cycles++;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("allocation_bitmap_engine_unit test failed");
			$finish;
		end
	end

	// Output side: ready in random stretches, with stall bursts when enabled.
	initial begin : result_sink
		int n;
		m_axis_tready <= 1'b0;
		@(posedge clk);
		forever begin
			if (rx_gaps && $urandom_range(0, 2) == 0) begin
				n = $urandom_range(1, 13);
				m_axis_tready <= 1'b0;
			end else begin
				n = $urandom_range(1, 16);
				m_axis_tready <= 1'b1;
			end
			repeat (n) @(posedge clk);
		end
	end

	// Main sequence: reset, directed table, random phases, final check.
	initial begin : stimulus
		cmd_t             cmd;
		logic [IDX_W-1:0] idx;
		logic [LEN_W-1:0] len;
		res_t             typed_res;
		int               value;

		errors = 0;
		quiet_cycles = 0;
		mark_bits = '0;
		size_reg = CFG_RESET;
		tx_gaps = 1'b1;
		rx_gaps = 1'b1;
		arst_n <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata <= '0;
		s_axis_tuser <= '0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// Directed table.
		for (int row = 0; row < PLAN_ROWS; row++) begin
			if (plan[row].is_cfg) begin
				write_size(plan[row].size);
			end else begin
				typed_res.result_index = plan[row].exp_index;
				typed_res.bit_value = plan[row].exp_bit;
				typed_res.status = plan[row].exp_status;
				maybe_gap();
				issue(plan[row].command, plan[row].bit_index, plan[row].run_length,
					plan[row].typed, typed_res);
			end
		end

		// Random phases, each at its own size; the last one runs without gaps.
		for (int ph = 0; ph < PHASES; ph++) begin
			value = (size_plan[ph] < 0) ? $urandom_range(1, MARKS) : size_plan[ph];
			write_size(CFG_W'(value));
			tx_gaps = (ph != PHASES - 1) && ($urandom_range(0, 2) != 0);
			rx_gaps = (ph != PHASES - 1) && ($urandom_range(0, 2) != 0);
			for (int k = 0; k < PHASE_ITEMS; k++) begin
				pick_command(cmd, idx, len);
				maybe_gap();
				issue(cmd, idx, len, 1'b0, typed_res);
			end
		end

		drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (errors == 0 && outcome_queue.size() == 0)
			$display("allocation_bitmap_engine_unit test passed");
		else
			$display("allocation_bitmap_engine_unit test failed");
		$finish;
	end

endmodule

// ----- allocation_bitmap_engine_unit.f -----
+incdir+src
src/abe_pkg.sv
src/abe_scan_unit.sv
src/abe_bitmap_store.sv
src/abe_sequencer.sv
src/allocation_bitmap_engine_unit.sv
verif/allocation_bitmap_engine_unit_test.sv
